// ===== rtl/lpbs_pkg.sv =====
`timescale 1ns / 1ps

package lpbs_pkg;

  localparam int NUM_LEDS_DEF = 8;
  localparam int MAX_SETS     = 8;
  localparam int IN_TDATA_W   = 104;
  localparam int OUT_TDATA_W  = 32;

  localparam logic [8:0]  CNT_ENDLESS = 9'h1FF;
  localparam logic [16:0] ON_FOREVER  = 17'h1FFFF;
  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
  localparam logic [4:0]  PRIO_RELEASE = 5'h1F;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  // command payload, last declared field (led_index) in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic [4:0]  cmd_priority;
    logic [15:0] burst_gap_ticks;
    logic [8:0]  burst_total;
    logic [8:0]  pulse_total;
    logic [15:0] off_ticks;
    logic [16:0] on_ticks;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [2:0]  led_index;
  } lpbs_in_t;

  typedef struct packed {
    logic [4:0] pad;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [2:0] out_index;
  } lpbs_out_t;

  // per-led sequence record
  typedef struct packed {
    logic        lit;
    logic [23:0] colour;
    logic [16:0] on_dur;
    logic [15:0] off_dur;
    logic [8:0]  pulse_reload;
    logic [8:0]  pulses;
    logic [8:0]  bursts;
    logic [15:0] gap;
    logic [3:0]  prio;
    logic [16:0] elapsed;
  } led_rec_t;

endpackage

// ===== rtl/led_pulse_burst_sequencer_top.sv =====
`timescale 1ns / 1ps

// Multi-channel RGB LED blink engine. A command transfer (tuser = 1) loads one
// LED's pulse and burst sequence, subject to that LED's held priority, and
// returns one colour set with tlast high; a rejected command returns nothing.
// A tick transfer (tuser = 0) advances every LED and returns one colour set for
// each LED that changes phase, in LED order, at most eight, tlast on the final
// one. All per-LED state sits in a state memory with one read and one write
// port that one shared update unit walks one LED per cycle; it waits while a
// finished colour set cannot yet be handed to the output side. The
// block takes no new transfer until the current one is done.
module led_pulse_burst_sequencer_top #(
  parameter int NUM_LEDS = lpbs_pkg::NUM_LEDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // led_index, red, green, blue, on_ticks, off_ticks, pulse_total,
  // burst_total, burst_gap_ticks, cmd_priority, zero pad
  input  logic [lpbs_pkg::IN_TDATA_W-1:0] in_tdata,
  // operation
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_index, out_red, out_green, out_blue, zero pad
  output logic [lpbs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import lpbs_pkg::*;

  localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_TICK,
    ST_FLUSH
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  lpbs_in_t          cmd_r, cmd_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [2:0]        pend_idx_r, pend_idx_nxt;
  logic [23:0]       pend_col_r, pend_col_nxt;
  logic              out_valid_r, out_valid_nxt;
  lpbs_out_t         out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  // state memory
  led_rec_t          mem [NUM_LEDS];
  logic [NUM_LEDS-1:0] valid_r;
  led_rec_t          rd_rec_r;
  logic              rd_vld_r;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  led_rec_t          wr_rec;

  // shared update unit
  led_rec_t          cur;
  led_rec_t          tick_rec, cmd_rec;
  logic              tick_chg;
  logic [23:0]       tick_col;
  logic [16:0]       el1;
  logic              cmd_ok;
  logic              slot_free;
  logic              push, push_last;
  logic [2:0]        push_idx;
  logic [23:0]       push_col;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign slot_free  = !out_valid_r || out_tready;

  assign cur = rd_vld_r ? rd_rec_r : '0;
  assign el1 = (cur.elapsed == ELAPSED_MAX) ? cur.elapsed : cur.elapsed + 17'd1;

  always_comb begin
    tick_rec = cur;
    tick_rec.elapsed = el1;
    tick_chg = 1'b0;
    tick_col = '0;
    if (cur.lit) begin
      if (cur.on_dur != ON_FOREVER &&
          $signed({1'b0, el1}) > $signed({cur.on_dur[16], cur.on_dur})) begin
        tick_rec.lit = 1'b0;
        tick_chg = 1'b1;
        if (cur.pulses != '0 || cur.bursts != '0) begin
          tick_rec.elapsed = '0;
        end else begin
          tick_rec.prio = '0;
        end
      end
    end else if (cur.pulses != '0) begin
      if (el1 > {1'b0, cur.off_dur}) begin
        tick_rec.lit = 1'b1;
        tick_chg = 1'b1;
        tick_col = cur.colour;
        if (cur.pulses != CNT_ENDLESS) begin
          tick_rec.pulses = cur.pulses - 9'd1;
        end
        tick_rec.elapsed = '0;
      end
    end else if (cur.bursts != '0) begin
      if (el1 > {1'b0, cur.gap}) begin
        tick_rec.lit = 1'b1;
        tick_chg = 1'b1;
        tick_col = cur.colour;
        if (cur.bursts != CNT_ENDLESS) begin
          tick_rec.bursts = cur.bursts - 9'd1;
        end
        tick_rec.pulses = cur.pulse_reload - 9'd1;
        tick_rec.elapsed = '0;
      end
    end
  end

  always_comb begin
    cmd_ok = (cmd_r.cmd_priority == PRIO_RELEASE) ||
             ($signed(cmd_r.cmd_priority) >= $signed({1'b0, cur.prio}));
    cmd_rec.lit          = 1'b1;
    cmd_rec.colour       = {cmd_r.red, cmd_r.green, cmd_r.blue};
    cmd_rec.on_dur       = cmd_r.on_ticks;
    cmd_rec.off_dur      = cmd_r.off_ticks;
    cmd_rec.pulse_reload = cmd_r.pulse_total;
    cmd_rec.pulses       = (!cmd_r.pulse_total[8] && cmd_r.pulse_total != '0) ?
                           cmd_r.pulse_total - 9'd1 : cmd_r.pulse_total;
    cmd_rec.bursts       = (!cmd_r.burst_total[8] && cmd_r.burst_total != '0) ?
                           cmd_r.burst_total - 9'd1 : cmd_r.burst_total;
    cmd_rec.gap          = cmd_r.burst_gap_ticks;
    cmd_rec.prio         = (cmd_r.cmd_priority == PRIO_RELEASE) ?
                           4'd0 : cmd_r.cmd_priority[3:0];
    cmd_rec.elapsed      = '0;
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    cmd_nxt      = cmd_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    pend_col_nxt = pend_col_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = idx_r;
    wr_rec       = tick_rec;
    push         = 1'b0;
    push_last    = 1'b0;
    push_idx     = pend_idx_r;
    push_col     = pend_col_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = lpbs_in_t'(in_tdata);
          if (in_tuser == OP_CMD) begin
            if (32'(cmd_nxt.led_index) < NUM_LEDS) begin
              rd_en     = 1'b1;
              rd_addr   = AW'(cmd_nxt.led_index);
              state_nxt = ST_CMD;
            end
          end else begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            idx_nxt    = '0;
            cnt_nxt    = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = ST_TICK;
          end
        end
      end
      ST_CMD: begin
        if (!cmd_ok) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          wr_en     = 1'b1;
          wr_addr   = AW'(cmd_r.led_index);
          wr_rec    = cmd_rec;
          push      = 1'b1;
          push_last = 1'b1;
          push_idx  = cmd_r.led_index;
          push_col  = cmd_rec.colour;
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (!(tick_chg && cnt_r < 4'(MAX_SETS) && pend_v_r && !slot_free)) begin
          wr_en = 1'b1;
          if (tick_chg && cnt_r < 4'(MAX_SETS)) begin
            push         = pend_v_r;
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = 3'(idx_r);
            pend_col_nxt = tick_col;
            cnt_nxt      = cnt_r + 4'd1;
          end
          if (idx_r == AW'(NUM_LEDS - 1)) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + AW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.pad       = '0;
      out_data_nxt.out_index = push_idx;
      out_data_nxt.out_red   = push_col[23:16];
      out_data_nxt.out_green = push_col[15:8];
      out_data_nxt.out_blue  = push_col[7:0];
      out_last_nxt           = push_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
    cmd_r      <= cmd_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_col_r <= pend_col_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      rd_rec_r <= mem[rd_addr];
      rd_vld_r <= valid_r[rd_addr];
    end
  end

endmodule

// ===== rtl/lpbs_checker.sv =====
`timescale 1ns / 1ps

module lpbs_port_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lpbs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import lpbs_pkg::*;

  // an accepted tick makes the block busy
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_TICK |=> !in_tready)
    else $error("tick transfer did not make the block busy");

  // a new result only comes out of a busy block
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without work in progress");

  // when idle, a waiting result must close its item
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && in_tready |-> out_tlast)
    else $error("idle with a non-final result waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind led_pulse_burst_sequencer_top lpbs_port_checker u_lpbs_port_checker (.*);

// ===== dv/lpbs_checker.sv =====
`timescale 1ns / 1ps

module lpbs_checker #(
  parameter int NUM_LEDS = lpbs_pkg::NUM_LEDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [lpbs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [lpbs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tlast,
  output int                               fail_count,
  output int                               pending,
  output int                               sets_checked,
  output int                               cmds_dropped
);
  import lpbs_pkg::*;

  typedef struct packed {
    logic [2:0] led;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } colour_set_t;

  // per-led sequence state
  logic        lit         [NUM_LEDS];
  logic [23:0] colour      [NUM_LEDS];
  logic [16:0] on_len      [NUM_LEDS];
  logic [15:0] off_len     [NUM_LEDS];
  logic [8:0]  reload      [NUM_LEDS];
  logic [8:0]  pulse_cnt   [NUM_LEDS];
  logic [8:0]  burst_cnt   [NUM_LEDS];
  logic [15:0] gap_len     [NUM_LEDS];
  logic [3:0]  prio_held   [NUM_LEDS];
  logic [16:0] since       [NUM_LEDS];

  colour_set_t expected_sets[$];
  int          errors;
  int          compared;
  int          dropped;

  function automatic colour_set_t make_set(input int led, input logic [23:0] c);
    colour_set_t cs;
    cs.led   = 3'(led);
    cs.red   = c[23:16];
    cs.green = c[15:8];
    cs.blue  = c[7:0];
    cs.last  = 1'b0;
    return cs;
  endfunction

  task automatic load_command(input lpbs_in_t d);
    int          led;
    colour_set_t cs;
    led = d.led_index;
    if (led >= NUM_LEDS) return;
    if (d.cmd_priority == PRIO_RELEASE) begin
      prio_held[led] = '0;
    end else if ($signed(d.cmd_priority) >= $signed({1'b0, prio_held[led]})) begin
      prio_held[led] = d.cmd_priority[3:0];
    end else begin
      dropped++;
      return;
    end
    colour[led]    = {d.red, d.green, d.blue};
    lit[led]       = 1'b1;
    on_len[led]    = d.on_ticks;
    off_len[led]   = d.off_ticks;
    reload[led]    = d.pulse_total;
    pulse_cnt[led] = ($signed(d.pulse_total) > 0) ? d.pulse_total - 9'd1 : d.pulse_total;
    burst_cnt[led] = ($signed(d.burst_total) > 0) ? d.burst_total - 9'd1 : d.burst_total;
    gap_len[led]   = d.burst_gap_ticks;
    since[led]     = '0;
    cs = make_set(led, colour[led]);
    cs.last = 1'b1;
    expected_sets.push_back(cs);
  endtask

  task automatic advance_tick();
    int          n;
    logic        changed;
    logic [23:0] c;
    colour_set_t held;
    n = 0;
    held = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (since[i] != ELAPSED_MAX) since[i] = since[i] + 17'd1;
    end
    for (int i = 0; i < NUM_LEDS; i++) begin
      changed = 1'b0;
      c = '0;
      if (lit[i]) begin
        if (on_len[i] != ON_FOREVER &&
            $signed({1'b0, since[i]}) > $signed({on_len[i][16], on_len[i]})) begin
          lit[i]  = 1'b0;
          changed = 1'b1;
          if (pulse_cnt[i] != '0 || burst_cnt[i] != '0) since[i] = '0;
          else prio_held[i] = '0;
        end
      end else if (pulse_cnt[i] != '0) begin
        if (since[i] > {1'b0, off_len[i]}) begin
          lit[i]  = 1'b1;
          changed = 1'b1;
          c       = colour[i];
          if (pulse_cnt[i] != CNT_ENDLESS) pulse_cnt[i] = pulse_cnt[i] - 9'd1;
          since[i] = '0;
        end
      end else if (burst_cnt[i] != '0) begin
        if (since[i] > {1'b0, gap_len[i]}) begin
          lit[i]  = 1'b1;
          changed = 1'b1;
          c       = colour[i];
          if (burst_cnt[i] != CNT_ENDLESS) burst_cnt[i] = burst_cnt[i] - 9'd1;
          pulse_cnt[i] = reload[i] - 9'd1;
          since[i] = '0;
        end
      end
      if (changed && n < MAX_SETS) begin
        if (n > 0) expected_sets.push_back(held);
        held = make_set(i, c);
        n++;
      end
    end
    if (n > 0) begin
      held.last = 1'b1;
      expected_sets.push_back(held);
    end
  endtask

  task automatic check_set(input lpbs_out_t got, input logic got_last);
    colour_set_t want;
    if (expected_sets.size() == 0) begin
      errors++;
      $display("%0t: unexpected colour set, expected none, %s %0d rgb %02h%02h%02h last %0b",
               $time, "actual led", got.out_index, got.out_red, got.out_green,
               got.out_blue, got_last);
      return;
    end
    want = expected_sets.pop_front();
    compared++;
    if (got.out_index !== want.led) begin
      errors++;
      $display("%0t: out_index expected %0d actual %0d", $time, want.led, got.out_index);
    end
    if (got.out_red !== want.red) begin
      errors++;
      $display("%0t: out_red expected %02h actual %02h", $time, want.red, got.out_red);
    end
    if (got.out_green !== want.green) begin
      errors++;
      $display("%0t: out_green expected %02h actual %02h", $time, want.green, got.out_green);
    end
    if (got.out_blue !== want.blue) begin
      errors++;
      $display("%0t: out_blue expected %02h actual %02h", $time, want.blue, got.out_blue);
    end
    if (got_last !== want.last) begin
      errors++;
      $display("%0t: out_tlast expected %0b actual %0b", $time, want.last, got_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        lit[i]       = 1'b0;
        colour[i]    = '0;
        on_len[i]    = '0;
        off_len[i]   = '0;
        reload[i]    = '0;
        pulse_cnt[i] = '0;
        burst_cnt[i] = '0;
        gap_len[i]   = '0;
        prio_held[i] = '0;
        since[i]     = '0;
      end
      expected_sets.delete();
      errors   = 0;
      compared = 0;
      dropped  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_CMD) load_command(in_tdata);
        else advance_tick();
      end
      if (out_tvalid && out_tready) check_set(out_tdata, out_tlast);
    end
    fail_count   <= errors;
    pending      <= expected_sets.size();
    sets_checked <= compared;
    cmds_dropped <= dropped;
  end

endmodule

// ===== dv/tb_led_pulse_burst_sequencer_top.sv =====
`timescale 1ns / 1ps

module tb_led_pulse_burst_sequencer_top;
  import lpbs_pkg::*;

  localparam int RANDOM_PER_PHASE = 110;

  logic     clk        = 1'b0;
  logic     rst_n      = 1'b0;
  logic     in_tvalid  = 1'b0;
  logic     in_tready;
  lpbs_in_t in_tdata   = '0;
  logic     in_tuser   = OP_TICK;
  logic     out_tvalid;
  logic     out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic     out_tlast;

  int fail_count;
  int pending;
  int sets_checked;
  int cmds_dropped;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int          cmds_sent = 0;
  int          ticks_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  led_pulse_burst_sequencer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  lpbs_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .pending      (pending),
    .sets_checked (sets_checked),
    .cmds_dropped (cmds_dropped)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input logic op, input lpbs_in_t d);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    if (op == OP_CMD) cmds_sent++;
    else ticks_sent++;
  endtask

  function automatic lpbs_in_t noise_payload();
    lpbs_in_t d;
    d = IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
    d.pad = '0;
    return d;
  endfunction

  task automatic send_cmd(input logic [2:0] led, input logic [23:0] rgb,
                          input logic [16:0] on, input logic [15:0] off,
                          input logic [8:0] pulses, input logic [8:0] bursts,
                          input logic [15:0] gap, input logic [4:0] prio);
    lpbs_in_t d;
    d = '0;
    d.led_index       = led;
    {d.red, d.green, d.blue} = rgb;
    d.on_ticks        = on;
    d.off_ticks       = off;
    d.pulse_total     = pulses;
    d.burst_total     = bursts;
    d.burst_gap_ticks = gap;
    d.cmd_priority    = prio;
    send_item(OP_CMD, d);
  endtask

  function automatic logic [8:0] pick_count();
    case ($urandom_range(7))
      0:       return CNT_ENDLESS;
      1:       return 9'($urandom);
      default: return 9'($urandom_range(4));
    endcase
  endfunction

  task automatic send_random_cmd();
    logic [16:0] on;
    logic [4:0]  prio;
    case ($urandom_range(9))
      0:       on = ON_FOREVER;
      1:       on = {1'b1, 16'($urandom)};
      default: on = 17'($urandom_range(4));
    endcase
    prio = $urandom_range(1) ? PRIO_RELEASE : 5'($urandom_range(15));
    send_cmd(3'($urandom), 24'($urandom), on, 16'($urandom_range(3)),
             pick_count(), pick_count(), 16'($urandom_range(4)), prio);
  endtask

  initial begin : stimulus
    int pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, priorities, endless and odd counts
    send_cmd(3'd0, 24'hFFFFFF, 17'd2, 16'd1, 9'd2, 9'd2, 16'd3, 5'd0);
    send_cmd(3'd7, 24'h000000, ON_FOREVER, 16'd0, 9'd1, 9'd1, 16'd0, 5'd15);
    send_cmd(3'd7, 24'hABCDEF, 17'd1, 16'd0, 9'd1, 9'd1, 16'd0, 5'd3);
    send_cmd(3'd7, 24'hABCDEF, 17'd1, 16'd0, 9'd1, 9'd1, 16'd0, 5'h10);
    send_cmd(3'd7, 24'h123456, 17'h1FFFE, 16'd0, 9'd0, 9'd2, 16'd0, PRIO_RELEASE);
    send_cmd(3'd1, 24'h00FF00, 17'd0, 16'd0, CNT_ENDLESS, CNT_ENDLESS, 16'd0, 5'd1);
    send_cmd(3'd2, 24'hFF0000, 17'd1, 16'd0, 9'h1FB, 9'h1FB, 16'd1, 5'd7);
    send_cmd(3'd3, 24'h0000FF, 17'd65535, 16'd65535, 9'd255, 9'd255, 16'd65535, 5'd15);
    send_cmd(3'd4, 24'h808080, 17'd0, 16'd0, 9'd1, 9'd1, 16'd0, 5'd2);
    send_cmd(3'd5, 24'h7F7F7F, 17'd0, 16'd0, 9'd1, 9'd1, 16'd0, 5'd2);
    send_cmd(3'd6, 24'h010203, 17'd0, 16'd0, 9'd1, 9'd1, 16'd0, 5'd2);
    repeat (12) send_item(OP_TICK, noise_payload());

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      repeat (RANDOM_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 60) send_item(OP_TICK, noise_payload());
        else if (pick < 90) send_random_cmd();
        else send_item(OP_CMD, noise_payload());
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (NUM_LEDS_DEF + 12) @(posedge clk);

    $display("covered %0d commands (%0d dropped on priority) and %0d ticks",
             cmds_sent, cmds_dropped, ticks_sent);
    $display("%0d colour sets compared across four idle and stall mixes", sets_checked);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lpbs_pkg.sv
rtl/led_pulse_burst_sequencer_top.sv
rtl/lpbs_checker.sv
dv/lpbs_checker.sv
dv/tb_led_pulse_burst_sequencer_top.sv
